[rtl/core/multilevel_dwt_analysis_core_defines.svh]
// Assertion macros for the wavelet analysis core.
`ifndef MULTILEVEL_DWT_ANALYSIS_CORE_DEFINES_SVH
`define MULTILEVEL_DWT_ANALYSIS_CORE_DEFINES_SVH
`ifndef SYNTH
`define DWT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DWT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define DWT_ASSERT(label, clk, rst_n, prop, msg)
`define DWT_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

[rtl/core/mdwt_pkg.sv]
// ----------------------------------------------------------------------------
// mdwt_pkg
// Shared constants and types of the wavelet analysis core.
// ----------------------------------------------------------------------------
package mdwt_pkg;
  localparam int unsigned Levels  = 2;
  localparam int unsigned Taps    = 4;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned LvW     = (Levels > 1) ? $clog2(Levels) : 1;
  localparam int unsigned TapW    = $clog2(Taps);
  localparam int unsigned CntW    = Levels + 1;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned AccW    = 40;

  typedef logic signed [15:0] coef_t;
  typedef logic signed [19:0] data_t;
  typedef logic signed [AccW-1:0] acc_t;

  // Data moved along the delay line of one level.
  typedef struct packed {
    logic  shift;
    data_t din;
  } cell_ctl_t;

  localparam coef_t TapReset [NumRegs] = '{
    16'sd15826, 16'sd27411, 16'sd7345, -16'sd4240, 16'sd0, 16'sd0, 16'sd0, 16'sd0
  };

  function automatic data_t scale_sat(acc_t acc);
    acc_t r;
    logic signed [AccW-15:0] q;
    r = (acc + acc_t'(16384)) >>> 15;
    q = r[AccW-15:0];
    if (q > $signed((AccW-14)'(524287))) return data_t'(20'sd524287);
    if (q < $signed(-(AccW-14)'(524288))) return data_t'(-20'sd524288);
    return q[19:0];
  endfunction
endpackage

[rtl/core/mdwt_cell.sv]
// ----------------------------------------------------------------------------
// mdwt_cell
// One stage of a level delay line; passes its word to the next cell on shift.
// ----------------------------------------------------------------------------
module mdwt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mdwt_pkg::cell_ctl_t ctl_i,
  output mdwt_pkg::data_t   dout_o
);
  import mdwt_pkg::*;
  data_t z_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_q <= '0;
    end else if (ctl_i.shift) begin
      z_q <= ctl_i.din;
    end
  end
  assign dout_o = z_q;
endmodule

[rtl/core/mdwt_level.sv]
// ----------------------------------------------------------------------------
// mdwt_level
// Delay line of one decomposition level built from a chain of cells.
// ----------------------------------------------------------------------------
module mdwt_level (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  mdwt_pkg::data_t din_i,
  output mdwt_pkg::data_t taps_o [mdwt_pkg::Taps]
);
  import mdwt_pkg::*;
  cell_ctl_t ctl [Taps];
  for (genvar k = 0; k < Taps; k++) begin : g_cell
    assign ctl[k].shift = shift_i;
    assign ctl[k].din   = (k == 0) ? din_i : taps_o[(k == 0) ? 0 : k - 1];
    mdwt_cell u_cell (.clk_i, .rst_ni, .ctl_i(ctl[k]), .dout_o(taps_o[k]));
  end
endmodule

[rtl/core/multilevel_dwt_analysis_core.sv]
// ----------------------------------------------------------------------------
// multilevel_dwt_analysis_core
// Multilevel wavelet analysis with one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload
// s_axis  | in  | tdata: sample[15:0]
// m_axis  | out | tdata: detail, approximation, approx_valid; tuser: level; tlast
// cfg     | in  | tap index 0..7, 16-bit tap value
// A sample is accepted only in idle; the sequencer then visits each level in turn
// and runs the products of each level that filters one at a time through the
// single multiplier.
// Reset clears delay lines, latches and counters; no clearing pass.
// A result waits in the output register; the sequencer stalls until taken.
// ----------------------------------------------------------------------------
`include "multilevel_dwt_analysis_core_defines.svh"
module multilevel_dwt_analysis_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // sample[15:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // detail[19:0], approximation[39:20], approx_valid[40], zero fill
  output logic [47:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,  // level[2:0]
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [mdwt_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import mdwt_pkg::*;

  localparam logic [1:0] StIdle = 2'd0, StMac = 2'd1, StEmit = 2'd2, StNext = 2'd3;

  coef_t tap_q [NumRegs];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) tap_q[i] <= TapReset[i];
    end else if (cfg_we_i) begin
      tap_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  logic [1:0] st_q, st_d;
  logic [LvW-1:0] lv_q, lv_d;
  logic [TapW:0] k_q, k_d;       // 0..2*Taps-1 product index
  logic [CntW-1:0] en_cnt_q [Levels];
  logic [CntW-1:0] dec_cnt_q [Levels];
  data_t latch_q [Levels];
  data_t x0_q;
  acc_t acc_lo_q, acc_hi_q;
  logic signed [36:0] prod_q;
  logic prod_v_q, prod_hi_q;
  logic [LvW-1:0] last_lv_q;

  // Delay lines.
  logic shift [Levels];
  data_t din [Levels];
  data_t z [Levels][Taps];
  for (genvar l = 0; l < Levels; l++) begin : g_lv
    assign din[l] = (l == 0) ? x0_q : latch_q[(l == 0) ? 0 : l - 1];
    mdwt_level u_level (.clk_i, .rst_ni, .shift_i(shift[l]), .din_i(din[l]),
                        .taps_o(z[l]));
  end

  logic fire, emit_now;
  assign fire     = (en_cnt_q[lv_q] == '0);
  assign emit_now = (dec_cnt_q[lv_q] == '0);

  // Last level that emits a result for this sample, resolved from the counters at acceptance.
  logic [LvW-1:0] last_fire;
  always_comb begin
    last_fire = '0;
    for (int l = 0; l < Levels; l++) begin
      if (en_cnt_q[l] == '0 && dec_cnt_q[l] == '0) last_fire = LvW'(l);
    end
  end

  logic [TapW-1:0] kt;
  logic ph;
  assign kt = k_q[TapW-1:0];
  assign ph = k_q[TapW];
  logic signed [16:0] coef;
  always_comb begin
    if (!ph) coef = 17'(tap_q[RegIdxW'(kt)]);
    else if (kt[0] == 1'b0) coef = -17'(tap_q[RegIdxW'(TapW'(Taps - 1) - kt)]);
    else coef = 17'(tap_q[RegIdxW'(TapW'(Taps - 1) - kt)]);
  end

  logic out_busy;
  assign out_busy = m_axis_tvalid && !m_axis_tready;

  always_comb begin
    st_d = st_q; lv_d = lv_q; k_d = k_q;
    for (int l = 0; l < Levels; l++) shift[l] = 1'b0;
    unique case (st_q)
      StIdle: if (s_axis_tvalid) begin st_d = StNext; lv_d = '0; end
      StNext: begin
        if (fire) begin
          shift[lv_q] = 1'b1;
          st_d = StMac; k_d = '0;
        end else if (lv_q == LvW'(Levels - 1)) st_d = StIdle;
        else lv_d = lv_q + 1'b1;
      end
      StMac: if (k_q == (TapW+1)'(2 * Taps - 1)) st_d = StEmit;
             else k_d = k_q + 1'b1;
      StEmit: if (!prod_v_q && !out_busy) begin
        if (lv_q == LvW'(Levels - 1)) st_d = StIdle;
        else begin st_d = StNext; lv_d = lv_q + 1'b1; end
      end
      default: st_d = StIdle;
    endcase
  end
  assign s_axis_tready = (st_q == StIdle);

  data_t lo, hi;
  assign lo = scale_sat(acc_lo_q);
  assign hi = scale_sat(acc_hi_q);
  logic emit_go;
  assign emit_go = (st_q == StEmit) && !prod_v_q && !out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; lv_q <= '0; k_q <= '0; prod_v_q <= 1'b0; prod_hi_q <= 1'b0;
      for (int l = 0; l < Levels; l++) begin
        en_cnt_q[l] <= '0; dec_cnt_q[l] <= '0; latch_q[l] <= '0;
      end
      x0_q <= '0; m_axis_tvalid <= 1'b0; acc_lo_q <= '0; acc_hi_q <= '0;
      last_lv_q <= '0; prod_q <= '0;
      m_axis_tuser <= '0; m_axis_tlast <= 1'b0; m_axis_tdata <= '0;
    end else begin
      st_q <= st_d; lv_q <= lv_d; k_q <= k_d;
      if (m_axis_tvalid && m_axis_tready && !(emit_go && emit_now)) m_axis_tvalid <= 1'b0;
      if (st_q == StIdle && s_axis_tvalid) begin
        x0_q <= 20'(signed'(s_axis_tdata));
        last_lv_q <= last_fire;
      end
      prod_v_q <= (st_q == StMac);
      prod_hi_q <= ph;
      prod_q <= coef * z[lv_q][kt];
      if (st_q == StNext && fire) begin acc_lo_q <= '0; acc_hi_q <= '0; end
      if (prod_v_q) begin
        if (prod_hi_q) acc_hi_q <= acc_hi_q + AccW'(prod_q);
        else acc_lo_q <= acc_lo_q + AccW'(prod_q);
      end
      if (st_q == StNext && !fire) begin
        en_cnt_q[lv_q] <= en_cnt_q[lv_q] - 1'b1;
        dec_cnt_q[lv_q] <= dec_cnt_q[lv_q] - 1'b1;
      end
      if (emit_go) begin
        en_cnt_q[lv_q] <= CntW'((1 << lv_q) - 1);
        if (emit_now) begin
          latch_q[lv_q] <= lo;
          dec_cnt_q[lv_q] <= CntW'((2 << lv_q) - 1);
          m_axis_tvalid <= 1'b1;
          m_axis_tuser <= 3'(lv_q);
          m_axis_tlast <= (lv_q == last_lv_q);
          m_axis_tdata <= {7'd0, (lv_q == LvW'(Levels - 1)),
                           (lv_q == LvW'(Levels - 1)) ? lo : data_t'(0), hi};
        end else begin
          dec_cnt_q[lv_q] <= dec_cnt_q[lv_q] - 1'b1;
        end
      end
    end
  end

  `DWT_ASSERT(a_ready_idle, clk_i, rst_ni, s_axis_tready |-> st_q == StIdle, "ready out of idle")
  `DWT_ASSERT_NEVER(a_emit_busy, clk_i, rst_ni, emit_go && out_busy, "emit over stalled result")
  `DWT_ASSERT(a_mac_after_fire, clk_i, rst_ni,
    (st_q == StNext && fire) |=> st_q == StMac, "fire without accumulate")
endmodule

[test/tb_multilevel_dwt_analysis_core.sv]
// ----------------------------------------------------------------------------
// Wavelet analysis core testbench
// Drives signed samples through the stream input, predicts every detail and
// approximation result with a behavioral model of the two-level analysis and
// compares each output transfer field by field, under varied taps and idling.
// ----------------------------------------------------------------------------
module tb_multilevel_dwt_analysis_core;
  timeunit 1ns;
  timeprecision 1ps;
  import mdwt_pkg::*;

  typedef struct {
    logic [2:0]         level;
    logic signed [19:0] detail;
    logic signed [19:0] approximation;
    logic               approx_valid;
    logic               last;
  } dwt_result_t;

  class dwt_scoreboard;
    logic signed [15:0] taps_q [NumRegs];
    logic signed [19:0] hist [Levels][Taps];
    logic signed [19:0] held_lo [Levels];
    int unsigned        en_cnt [Levels];
    int unsigned        dec_cnt [Levels];
    dwt_result_t        pending [$];
    int                 errors;

    function new();
      for (int i = 0; i < NumRegs; i++) taps_q[i] = TapReset[i];
      for (int l = 0; l < Levels; l++) begin
        held_lo[l] = '0;
        en_cnt[l] = 0;
        dec_cnt[l] = 0;
        for (int k = 0; k < Taps; k++) hist[l][k] = '0;
      end
      errors = 0;
    endfunction

    function void write_tap(int idx, logic [15:0] v);
      if (idx < NumRegs) taps_q[idx] = v;
    endfunction

    function logic signed [19:0] round_sat(longint acc);
      longint q;
      q = (acc + 16384) >>> 15;
      if (q > 524287) return 20'sd524287;
      if (q < -524288) return -20'sd524288;
      return q[19:0];
    endfunction

    function void note_sample(logic signed [15:0] smp);
      int first;
      first = pending.size();
      for (int l = 0; l < Levels; l++) begin
        int unsigned wrap;
        wrap = (4 << l) - 1;
        if (en_cnt[l] == 0) begin
          longint al, ah, h;
          logic signed [19:0] lo, hi;
          dwt_result_t r;
          for (int k = Taps - 1; k > 0; k--) hist[l][k] = hist[l][k-1];
          hist[l][0] = (l == 0) ? 20'(smp) : held_lo[l-1];
          al = 0;
          ah = 0;
          for (int k = 0; k < Taps; k++) begin
            h = longint'(taps_q[Taps-1-k]);
            if ((k & 1) == 0) h = -h;
            al += longint'(taps_q[k]) * longint'(hist[l][k]);
            ah += h * longint'(hist[l][k]);
          end
          lo = round_sat(al);
          hi = round_sat(ah);
          en_cnt[l] = 1 << l;
          if (dec_cnt[l] == 0) begin
            held_lo[l] = lo;
            dec_cnt[l] = 2 << l;
            r.level = 3'(l);
            r.detail = hi;
            r.approx_valid = (l == Levels - 1);
            r.approximation = r.approx_valid ? lo : 20'sd0;
            r.last = 1'b0;
            pending.push_back(r);
          end
        end
        en_cnt[l] = (en_cnt[l] - 1) & wrap;
        dec_cnt[l] = (dec_cnt[l] - 1) & wrap;
      end
      if (pending.size() > first) pending[pending.size()-1].last = 1'b1;
    endfunction

    function void check_result(dwt_result_t got);
      dwt_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result level=%0d detail=%0d", $time, got.level, got.detail);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.level !== exp.level) begin
        $display("%0t: level expected %0d actual %0d", $time, exp.level, got.level);
        errors++;
      end
      if (got.detail !== exp.detail) begin
        $display("%0t: detail expected %0d actual %0d", $time, exp.detail, got.detail);
        errors++;
      end
      if (got.approximation !== exp.approximation) begin
        $display("%0t: approximation expected %0d actual %0d", $time, exp.approximation,
                 got.approximation);
        errors++;
      end
      if (got.approx_valid !== exp.approx_valid) begin
        $display("%0t: approx_valid expected %0b actual %0b", $time, exp.approx_valid,
                 got.approx_valid);
        errors++;
      end
      if (got.last !== exp.last) begin
        $display("%0t: last expected %0b actual %0b", $time, exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  localparam int WatchdogLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [RegIdxW-1:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  dwt_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;

  always #6 clk_i = ~clk_i;

  multilevel_dwt_analysis_core DUT (.*);

  // Sample both sides at the rising edge; the receiver's ready changes on the falling edge.
  always @(posedge clk_i) begin
    dwt_result_t r;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        r.detail = m_axis_tdata[19:0];
        r.approximation = m_axis_tdata[39:20];
        r.approx_valid = m_axis_tdata[40];
        r.level = m_axis_tuser;
        r.last = m_axis_tlast;
        sb.check_result(r);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Valid stays high after a transfer so that samples can follow back to back;
  // idle cycles and the drain drop it.
  task automatic send_sample(logic [15:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_tap(int idx, logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx[RegIdxW-1:0];
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_tap(idx, v);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(4))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(63)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes at reset taps, steps and impulses.
    for (int i = 0; i < 6; i++) send_sample(16'h7fff);
    for (int i = 0; i < 6; i++) send_sample(16'h8000);
    send_sample(16'h0001);
    send_sample(16'hffff);
    for (int i = 0; i < 4; i++) send_sample(16'h0000);
    drain();

    // Extreme taps drive saturation and the negated most negative tap.
    for (int i = 0; i < NumRegs; i++) write_tap(i, (i % 2) ? 16'h7fff : 16'h8000);
    for (int i = 0; i < 8; i++) send_sample((i % 2) ? 16'h8000 : 16'h7fff);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int i = 0; i < NumRegs; i++) write_tap(i, 16'($urandom));
      if (ph == 1) write_tap(1, 16'h7fff);
      if (ph == 2) write_tap(0, 16'h8000);
      for (int i = 0; i < 75; i++) send_sample(rand_sample());
      drain();
    end

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
